/* hdl/cdp_pkg.sv */
// Shared types, constants and character helpers of the cookie date parser.
package cdp_pkg;

  localparam int CHAR_W        = 8;
  localparam int TOKEN_LEN_W   = 4;
  localparam int HEAD_CHARS    = 3;
  localparam int HEAD_IDX_W    = $clog2(HEAD_CHARS);
  localparam int NUMBER_DIGITS = 4;
  localparam int NUMBER_W      = 14;
  localparam int CLOCK_FIELD_W = 7;
  localparam int CURSOR_W      = 4;
  localparam int DIGIT_W       = 4;
  localparam int HOUR_W        = 5;
  localparam int MINUTE_W      = 6;
  localparam int YEAR_W        = 14;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int SECONDS_W     = 17;
  localparam int PIVOT_W       = 7;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 14;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_FIELDS_W  = 1 + YEAR_W + MONTH_W + DAY_W + SECONDS_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [CFG_INDEX_W-1:0] REG_YEAR_PIVOT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_YEAR   = 1'b1;

  localparam logic [PIVOT_W-1:0] PIVOT_RESET    = 7'd70;
  localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 14'd1601;

  localparam logic [TOKEN_LEN_W-1:0]   TOKEN_LEN_MAX    = 4'd15;
  localparam logic [TOKEN_LEN_W-1:0]   TIME_MIN_LEN     = 4'd4;
  localparam logic [CURSOR_W-1:0]      CURSOR_DONE      = 4'd9;
  localparam logic [CURSOR_W-1:0]      CURSOR_COMPLETE  = 4'd7;
  localparam logic [CLOCK_FIELD_W-1:0] MAX_HOUR         = 7'd23;
  localparam logic [CLOCK_FIELD_W-1:0] MAX_MINUTE       = 7'd59;
  localparam logic [NUMBER_W-1:0]      MAX_DAY          = 14'd31;
  localparam logic [YEAR_W-1:0]        TWO_DIGIT_LIMIT  = 14'd100;
  localparam logic [YEAR_W-1:0]        CENTURY_21       = 14'd2000;
  localparam logic [YEAR_W-1:0]        CENTURY_20       = 14'd1900;
  localparam logic [SECONDS_W-1:0]     SECONDS_PER_HOUR = 17'd3600;
  localparam logic [SECONDS_W-1:0]     SECONDS_PER_MIN  = 17'd60;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [TOKEN_LEN_W-1:0]                  len;
    logic [HEAD_CHARS-1:0][CHAR_W-1:0]       head;
    logic [NUMBER_W-1:0]                     number;
    logic                                    all_digits;
    logic [2:0][CLOCK_FIELD_W-1:0]           fields;
    logic [CURSOR_W-1:0]                     cursor;
    logic                                    bad;
  } token_t;

  typedef struct packed {
    logic                have_time;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MINUTE_W-1:0] second;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic                failed;
  } found_t;

  typedef struct packed {
    logic                date_valid;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MINUTE_W-1:0] second;
  } rec_t;

  localparam token_t TOKEN_CLEAR = '{len: '0, head: '0, number: '0, all_digits: 1'b1,
                                     fields: '0, cursor: '0, bad: 1'b0};
  localparam found_t FOUND_CLEAR = '0;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_token_char(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) || (c == CHAR_COLON);
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [MONTH_W-1:0] month_code(input logic [3*CHAR_W-1:0] w);
    logic [MONTH_W-1:0] m;
    case (w)
      "jan":   m = 4'd1;
      "feb":   m = 4'd2;
      "mar":   m = 4'd3;
      "apr":   m = 4'd4;
      "may":   m = 4'd5;
      "jun":   m = 4'd6;
      "jul":   m = 4'd7;
      "aug":   m = 4'd8;
      "sep":   m = 4'd9;
      "oct":   m = 4'd10;
      "nov":   m = 4'd11;
      "dec":   m = 4'd12;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  // Weekday names and the zone name carry no date information.
  function automatic logic is_skip_word(input logic [3*CHAR_W-1:0] w);
    logic s;
    case (w) inside
      "sun", "mon", "tue", "wed", "thu", "fri", "sat", "gmt": s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

/* hdl/cdp_token.sv */
// Per-byte tokenizer and token classifier holding the parse state.
module cdp_token import cdp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CHAR_W-1:0]        in_char,
  input  logic                     in_last,
  input  logic [PIVOT_W-1:0]       year_pivot,
  input  logic [YEAR_W-1:0]        min_year,
  output logic                     rec_valid,
  input  logic                     rec_ready,
  output rec_t                     rec
);

  token_t tok, tok_app, tok_next, tgt;
  found_t found, found_cls, found_next;
  rec_t   rec_next;
  logic   accept, tok_char, digit, do_class;
  logic [DIGIT_W-1:0] dval;
  logic [1:0] fidx, phase;
  logic [CLOCK_FIELD_W-1:0] fcur;
  logic time_cand, complete, skip, date_ok;
  logic [MONTH_W-1:0] mcode;
  logic [3*CHAR_W-1:0] word;
  logic [YEAR_W-1:0] year_val;

  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;
  assign tok_char = is_token_char(in_char);
  assign digit    = is_digit(in_char);
  assign dval     = DIGIT_W'(in_char - CHAR_ZERO);

  always_comb begin
    unique case (tok.cursor)
      4'd0, 4'd1, 4'd2: fidx = 2'd0;
      4'd3, 4'd4, 4'd5: fidx = 2'd1;
      4'd6, 4'd7, 4'd8: fidx = 2'd2;
      default:          fidx = 2'd0;
    endcase
    unique case (tok.cursor)
      4'd0, 4'd3, 4'd6: phase = 2'd0;
      4'd1, 4'd4, 4'd7: phase = 2'd1;
      4'd2, 4'd5, 4'd8: phase = 2'd2;
      default:          phase = 2'd0;
    endcase
  end

  assign fcur = tok.fields[fidx];

  always_comb begin
    tok_app = tok;
    if (tok.len < TOKEN_LEN_W'(HEAD_CHARS)) begin
      tok_app.head[tok.len[HEAD_IDX_W-1:0]] = in_char;
    end
    if (!digit) begin
      tok_app.all_digits = 1'b0;
    end else if (tok.len < TOKEN_LEN_W'(NUMBER_DIGITS)) begin
      tok_app.number = NUMBER_W'(tok.number * NUMBER_W'(10) + NUMBER_W'(dval));
    end
    if (!tok.bad && (tok.cursor < CURSOR_DONE)) begin
      if (phase == 2'd0) begin
        if (digit) begin
          tok_app.fields[fidx] = CLOCK_FIELD_W'(dval);
          tok_app.cursor = tok.cursor + CURSOR_W'(1);
        end else begin
          tok_app.bad = 1'b1;
        end
      end else if (in_char == CHAR_COLON) begin
        tok_app.cursor = CURSOR_W'((CURSOR_W'(fidx) + CURSOR_W'(1)) * CURSOR_W'(3));
      end else if ((phase == 2'd1) && digit) begin
        tok_app.fields[fidx] = CLOCK_FIELD_W'(fcur * CLOCK_FIELD_W'(10) + CLOCK_FIELD_W'(dval));
        tok_app.cursor = tok.cursor + CURSOR_W'(1);
      end else begin
        tok_app.bad = 1'b1;
      end
    end
    if (tok.len != TOKEN_LEN_MAX) begin
      tok_app.len = tok.len + TOKEN_LEN_W'(1);
    end
  end

  assign tgt      = tok_char ? tok_app : tok;
  assign do_class = (!tok_char || in_last) && (tgt.len != '0) && !found.failed;
  assign word     = {to_lower(tgt.head[0]), to_lower(tgt.head[1]), to_lower(tgt.head[2])};
  assign mcode    = month_code(word);
  assign skip     = is_skip_word(word);
  assign time_cand = !found.have_time && (tgt.len > TIME_MIN_LEN) &&
                     ((tgt.head[1] == CHAR_COLON) || (tgt.head[2] == CHAR_COLON));
  assign complete = !tgt.bad && (tgt.cursor >= CURSOR_COMPLETE);

  always_comb begin
    year_val = YEAR_W'(tgt.number);
    if (year_val < TWO_DIGIT_LIMIT) begin
      year_val = year_val + ((year_val < YEAR_W'(year_pivot)) ? CENTURY_21 : CENTURY_20);
    end
  end

  always_comb begin
    found_cls = found;
    if (time_cand && complete) begin
      if ((tgt.fields[0] > MAX_HOUR) || (tgt.fields[1] > MAX_MINUTE) ||
          (tgt.fields[2] > MAX_MINUTE)) begin
        found_cls.failed = 1'b1;
      end else begin
        found_cls.have_time = 1'b1;
        found_cls.hour      = tgt.fields[0][HOUR_W-1:0];
        found_cls.minute    = tgt.fields[1][MINUTE_W-1:0];
        found_cls.second    = tgt.fields[2][MINUTE_W-1:0];
      end
    end else if ((found.day == '0) && (tgt.len <= TOKEN_LEN_W'(2))) begin
      if (tgt.all_digits && (tgt.number != '0) && (tgt.number <= MAX_DAY)) begin
        found_cls.day = tgt.number[DAY_W-1:0];
      end else begin
        found_cls.failed = 1'b1;
      end
    end else if ((found.month == '0) && (tgt.len == TOKEN_LEN_W'(3))) begin
      if (mcode != '0) begin
        found_cls.month = mcode;
      end else if (!skip) begin
        found_cls.failed = 1'b1;
      end
    end else if ((found.year == '0) && tgt.all_digits &&
                 ((tgt.len == TOKEN_LEN_W'(2)) || (tgt.len == TOKEN_LEN_W'(4)))) begin
      if (year_val < min_year) begin
        found_cls.failed = 1'b1;
      end else begin
        found_cls.year = year_val;
      end
    end
  end

  assign found_next = do_class ? found_cls : found;
  assign tok_next   = (tok_char && !in_last) ? tok_app : TOKEN_CLEAR;
  assign date_ok    = !found_next.failed && found_next.have_time && (found_next.day != '0) &&
                      (found_next.month != '0) && (found_next.year != '0);

  always_comb begin
    rec_next = '0;
    if (date_ok) begin
      rec_next.date_valid = 1'b1;
      rec_next.year       = found_next.year;
      rec_next.month      = found_next.month;
      rec_next.day        = found_next.day;
      rec_next.hour       = found_next.hour;
      rec_next.minute     = found_next.minute;
      rec_next.second     = found_next.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok       <= TOKEN_CLEAR;
      found     <= FOUND_CLEAR;
      rec_valid <= 1'b0;
    end else begin
      if (accept) begin
        tok   <= tok_next;
        found <= in_last ? FOUND_CLEAR : found_next;
      end
      if (accept && in_last) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      rec <= rec_next;
    end
  end

endmodule

/* hdl/cdp_out.sv */
// Output register stage that forms seconds of day and drives the result stream.
module cdp_out import cdp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  rec_t                   rec,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [SECONDS_W-1:0] seconds;

  assign rec_ready = !m_tvalid || m_tready;
  assign seconds   = SECONDS_W'(SECONDS_W'(rec.hour) * SECONDS_PER_HOUR) +
                     SECONDS_W'(SECONDS_W'(rec.minute) * SECONDS_PER_MIN) +
                     SECONDS_W'(rec.second);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rec_ready) begin
      m_tvalid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      m_tdata <= {OUT_PAD_W'(0), seconds, rec.day, rec.month, rec.year, rec.date_valid};
    end
  end

endmodule

/* hdl/http_cookie_date_parser.sv */
// Top level of the cookie Expires date parser.
// Accepts one byte per cycle, with no gaps between strings, unless m_tready holds the output.
// The byte with tlast loads the result stage; the output register then drives the master side.
// The tokenizer state is a registered loop; one result stage and one output register follow.
// Reset clears the parse state and the valid flags of both stages, and sets year_pivot to 70 and min_year to 1601.
module http_cookie_date_parser import cdp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] text_char
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] date_valid, [14:1] year_out, [18:15] month_out, [23:19] day_out,
  // [40:24] seconds_of_day, [47:41] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [PIVOT_W-1:0] year_pivot;
  logic [YEAR_W-1:0]  min_year;
  logic               rec_valid, rec_ready;
  rec_t               rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_pivot <= PIVOT_RESET;
      min_year   <= MIN_YEAR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_YEAR_PIVOT: year_pivot <= cfg_wdata[PIVOT_W-1:0];
        REG_MIN_YEAR:   min_year   <= cfg_wdata[YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  cdp_token u_token (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata[CHAR_W-1:0]),
    .in_last    (s_tlast),
    .year_pivot (year_pivot),
    .min_year   (min_year),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  cdp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* hdl/cdp_checker.sv */
// Port-level checker for the cookie date parser and its bind to the top level.
module cdp_checker import cdp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result stream not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("Stalled result transfer changed.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("Invalid date carries nonzero fields.");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |->
      ((m_tdata[18:15] != 4'd0) && (m_tdata[18:15] <= 4'd12) &&
       (m_tdata[23:19] != 5'd0) && (m_tdata[40:24] < 17'd86400) &&
       (m_tdata[14:1] != 14'd0)))
    else $error("Valid date has a field out of range.");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast && !m_tvalid) |=> ##1 m_tvalid)
    else $error("No result after the last byte of a string.");

endmodule

bind http_cookie_date_parser cdp_checker u_cdp_checker (.*);
